FILE: hdl/lfcl_pkg.sv
// Shared widths, codes and constants of the length-framed channel loader.
`default_nettype none

package lfcl_pkg;

  localparam int BYTE_W = 8;
  localparam int CH_W   = 9;
  localparam int CNT_W  = 10;
  localparam int LEN_W  = 16;
  localparam int STAT_W = 2;
  localparam int PH_W   = 3;

  localparam int CHANNELS_DEF = 512;
  localparam logic [CNT_W-1:0] MAX_LEN_RST = 10'd512;

  localparam logic [BYTE_W-1:0] HDR_O = 8'h4f;
  localparam logic [BYTE_W-1:0] HDR_V = 8'h56;
  localparam logic [BYTE_W-1:0] HDR_D = 8'h44;

  // Result status codes.
  localparam logic [STAT_W-1:0] STAT_NONE   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_COMMIT = 2'd1;
  localparam logic [STAT_W-1:0] STAT_LONG   = 2'd2;
  localparam logic [STAT_W-1:0] STAT_TRAIL  = 2'd3;

  // Parser phases.
  localparam logic [PH_W-1:0] PH_SEARCH = 3'd0;
  localparam logic [PH_W-1:0] PH_GOT_O  = 3'd1;
  localparam logic [PH_W-1:0] PH_GOT_OV = 3'd2;
  localparam logic [PH_W-1:0] PH_LEN_HI = 3'd3;
  localparam logic [PH_W-1:0] PH_LEN_LO = 3'd4;
  localparam logic [PH_W-1:0] PH_DATA   = 3'd5;
  localparam logic [PH_W-1:0] PH_TRAIL0 = 3'd6;
  localparam logic [PH_W-1:0] PH_TRAIL1 = 3'd7;

  typedef logic [BYTE_W-1:0] byte_t;

endpackage

`default_nettype wire

FILE: hdl/length_framed_channel_loader_unit.sv
// Top level of the length-framed channel loader: parser, staging and channel memories.
//
//  channel | handshake               | payload
//  --------+-------------------------+-------------------------------------------
//  in      | in_valid / in_stall     | in_command, in_rx_byte, in_channel
//  out     | out_valid / out_stall   | out_status, out_read_data, out_committed_length
//  cfg     | cfg_wr_en               | cfg_wr_data (max_data_length)
//
// A stream beat loads its result into the output register directly; a read beat goes
// through the registered read port of the channel memory and the read state first.
// A committed frame of N data bytes then holds the input while the staging memory is
// copied into the channel memory, one byte per cycle.
// After reset the channel memory is cleared one entry per cycle, with in_stall high;
// configuration writes are taken throughout.
// The output register lets a new beat in while the previous result is being taken.
`default_nettype none

module length_framed_channel_loader_unit
  import lfcl_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_stall,
  input  wire                    in_command,
  input  wire  [BYTE_W-1:0]      in_rx_byte,
  input  wire  [CH_W-1:0]        in_channel,
  output logic                   out_valid,
  input  wire                    out_stall,
  output logic [STAT_W-1:0]      out_status,
  output logic [BYTE_W-1:0]      out_read_data,
  output logic [CNT_W-1:0]       out_committed_length,
  input  wire                    cfg_wr_en,
  input  wire  [CNT_W-1:0]       cfg_wr_data
);

  localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_READ  = 2'd2;
  localparam logic [1:0] ST_COPY  = 2'd3;

  byte_t stg_mem  [CHANNELS];
  byte_t chan_mem [CHANNELS];

  logic [1:0]       ctrl_r, ctrl_nxt;
  logic [IW-1:0]    clr_cnt_r, clr_cnt_nxt;
  logic [CNT_W-1:0] cp_cnt_r, cp_cnt_nxt;
  logic             wr_pend_r, wr_pend_nxt;
  logic [IW-1:0]    wr_idx_r, wr_idx_nxt;
  logic [CNT_W-1:0] max_len_r;

  logic [PH_W-1:0]  phase_r, phase_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [CNT_W-1:0] dcnt_r, dcnt_nxt;
  logic             trl_ok_r, trl_ok_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] out_status_r;
  byte_t            out_rdata_r;
  logic [CNT_W-1:0] out_clen_r;

  logic             load_out;
  logic [STAT_W-1:0] res_status;
  byte_t            res_rdata;
  logic [CNT_W-1:0] res_clen;

  logic             in_acc;
  logic             rd_inrange_r;
  byte_t            ch_rdata_r;
  byte_t            stg_rdata_r;

  logic [31:0]      ch_ext, dcnt_ext, cp_ext;
  logic             rd_inrange;
  logic             stg_wr_en;
  logic             stg_rd_en;
  logic             ch_rd_en;
  logic [LEN_W-1:0] len_full;
  logic [CNT_W-1:0] dcnt_inc;
  logic [CNT_W-1:0] cp_cnt_inc;
  logic             trail_ok_final;

  assign in_stall = !((ctrl_r == ST_IDLE) && !wr_pend_r && (!out_valid_r || !out_stall));
  assign in_acc   = in_valid && !in_stall;

  assign ch_ext     = 32'(in_channel);
  assign dcnt_ext   = 32'(dcnt_r);
  assign cp_ext     = 32'(cp_cnt_r);
  assign rd_inrange = ch_ext < 32'(CHANNELS);
  assign ch_rd_en   = in_acc && in_command && rd_inrange;
  assign len_full   = {len_r[LEN_W-1:BYTE_W], in_rx_byte};
  assign dcnt_inc   = dcnt_r + 10'd1;
  assign cp_cnt_inc = cp_cnt_r + 10'd1;
  assign trail_ok_final = trl_ok_r && (in_rx_byte == '0);

  always_comb begin
    ctrl_nxt    = ctrl_r;
    clr_cnt_nxt = clr_cnt_r;
    cp_cnt_nxt  = cp_cnt_r;
    wr_pend_nxt = 1'b0;
    wr_idx_nxt  = wr_idx_r;
    phase_nxt   = phase_r;
    len_nxt     = len_r;
    dcnt_nxt    = dcnt_r;
    trl_ok_nxt  = trl_ok_r;
    stg_wr_en   = 1'b0;
    stg_rd_en   = 1'b0;
    load_out    = 1'b0;
    res_status  = STAT_NONE;
    res_rdata   = '0;
    res_clen    = '0;

    case (ctrl_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == IW'(CHANNELS - 1)) begin
          ctrl_nxt = ST_IDLE;
        end
      end
      ST_READ: begin
        load_out  = 1'b1;
        res_rdata = rd_inrange_r ? ch_rdata_r : '0;
        ctrl_nxt  = ST_IDLE;
      end
      ST_COPY: begin
        // Read the staged byte now; it is written to the channel memory next cycle.
        stg_rd_en   = 1'b1;
        wr_pend_nxt = 1'b1;
        wr_idx_nxt  = cp_ext[IW-1:0];
        cp_cnt_nxt  = cp_cnt_inc;
        if (cp_cnt_inc == len_r[CNT_W-1:0]) begin
          ctrl_nxt = ST_IDLE;
        end
      end
      default: begin
        if (in_acc && in_command) begin
          ctrl_nxt = ST_READ;
        end else if (in_acc) begin
          load_out = 1'b1;
          case (phase_r)
            PH_SEARCH: phase_nxt = (in_rx_byte == HDR_O) ? PH_GOT_O : PH_SEARCH;
            PH_GOT_O: begin
              if (in_rx_byte == HDR_V) begin
                phase_nxt = PH_GOT_OV;
              end else begin
                phase_nxt = (in_rx_byte == HDR_O) ? PH_GOT_O : PH_SEARCH;
              end
            end
            PH_GOT_OV: begin
              if (in_rx_byte == HDR_D) begin
                phase_nxt = PH_LEN_HI;
              end else begin
                phase_nxt = (in_rx_byte == HDR_O) ? PH_GOT_O : PH_SEARCH;
              end
            end
            PH_LEN_HI: begin
              len_nxt   = {in_rx_byte, 8'h00};
              phase_nxt = PH_LEN_LO;
            end
            PH_LEN_LO: begin
              len_nxt    = len_full;
              dcnt_nxt   = '0;
              trl_ok_nxt = 1'b1;
              if ((len_full > {6'b0, max_len_r}) || (32'(len_full) > 32'(CHANNELS))) begin
                res_status = STAT_LONG;
                phase_nxt  = PH_SEARCH;
              end else begin
                phase_nxt = (len_full == '0) ? PH_TRAIL0 : PH_DATA;
              end
            end
            PH_DATA: begin
              stg_wr_en = dcnt_ext < 32'(CHANNELS);
              dcnt_nxt  = dcnt_inc;
              if ({6'b0, dcnt_inc} >= len_r) begin
                phase_nxt = PH_TRAIL0;
              end
            end
            PH_TRAIL0: begin
              trl_ok_nxt = (in_rx_byte == '0);
              phase_nxt  = PH_TRAIL1;
            end
            default: begin
              trl_ok_nxt = trail_ok_final;
              phase_nxt  = PH_SEARCH;
              if (trail_ok_final && (32'(len_r) <= 32'(CHANNELS))) begin
                res_status = STAT_COMMIT;
                res_clen   = len_r[CNT_W-1:0];
                cp_cnt_nxt = '0;
                if (len_r != '0) begin
                  ctrl_nxt = ST_COPY;
                end
              end else begin
                res_status = STAT_TRAIL;
              end
            end
          endcase
        end
      end
    endcase
  end

  assign out_valid_nxt = load_out ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r      <= ST_CLEAR;
      clr_cnt_r   <= '0;
      cp_cnt_r    <= '0;
      wr_pend_r   <= 1'b0;
      max_len_r   <= MAX_LEN_RST;
      phase_r     <= PH_SEARCH;
      len_r       <= '0;
      dcnt_r      <= '0;
      trl_ok_r    <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      ctrl_r      <= ctrl_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      cp_cnt_r    <= cp_cnt_nxt;
      wr_pend_r   <= wr_pend_nxt;
      phase_r     <= phase_nxt;
      len_r       <= len_nxt;
      dcnt_r      <= dcnt_nxt;
      trl_ok_r    <= trl_ok_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        max_len_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    wr_idx_r <= wr_idx_nxt;
    if (in_acc && in_command) begin
      rd_inrange_r <= rd_inrange;
    end
    if (load_out) begin
      out_status_r <= res_status;
      out_rdata_r  <= res_rdata;
      out_clen_r   <= res_clen;
    end
  end

  // Staging memory: data beats write, the commit copy reads.
  always_ff @(posedge clk) begin
    if (stg_wr_en) begin
      stg_mem[dcnt_ext[IW-1:0]] <= in_rx_byte;
    end
    if (stg_rd_en) begin
      stg_rdata_r <= stg_mem[cp_ext[IW-1:0]];
    end
  end

  // Channel memory: one write port for clearing and copying, one read port for reads.
  always_ff @(posedge clk) begin
    if (ctrl_r == ST_CLEAR) begin
      chan_mem[clr_cnt_r] <= '0;
    end else if (wr_pend_r) begin
      chan_mem[wr_idx_r] <= stg_rdata_r;
    end
    if (ch_rd_en) begin
      ch_rdata_r <= chan_mem[ch_ext[IW-1:0]];
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_read_data        = out_rdata_r;
  assign out_committed_length = out_clen_r;

  // A pending copy write only ever follows a copy read.
  a_wr_after_copy: assert property (@(posedge clk) disable iff (!rst_n)
    wr_pend_r |-> $past(ctrl_r) == ST_COPY)
    else $error("channel write without a preceding staging read");

  // No beat is taken while the channel memory has a write in flight.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl_r == ST_COPY || ctrl_r == ST_CLEAR || wr_pend_r) |-> in_stall)
    else $error("beat accepted during clear or copy");

  // A result is never loaded over one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> (!out_valid_r || !out_stall))
    else $error("result register overwritten");

  // The read state is entered only after an accepted read beat.
  a_read_origin: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl_r == ST_READ) |-> $past(in_acc && in_command))
    else $error("read result without a read beat");

  // A nonzero committed length comes only with a commit status.
  a_clen_commit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_clen_r != '0) |-> out_status_r == STAT_COMMIT)
    else $error("committed length without commit status");

endmodule

`default_nettype wire

FILE: tb/length_framed_channel_loader_unit_test.sv
// Self-checking testbench for the length-framed channel loader top level.
`default_nettype none

module length_framed_channel_loader_unit_test;
  import lfcl_pkg::*;

  localparam logic CMD_RX   = 1'b0;
  localparam logic CMD_READ = 1'b1;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_BEATS   = 55;
  localparam int LONG_FRAME    = 48;

  typedef enum logic [1:0] {KIND_BEAT, KIND_CFG, KIND_DRAIN} step_kind_t;

  typedef struct {
    logic            command;
    byte_t           rx_byte;
    logic [CH_W-1:0] channel;
  } loader_beat_t;

  typedef struct {
    logic [STAT_W-1:0] status;
    byte_t             read_data;
    logic [CNT_W-1:0]  committed_length;
  } loader_result_t;

  typedef struct {
    step_kind_t       kind;
    loader_beat_t     beat;
    logic [CNT_W-1:0] limit;
  } plan_step_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_command = CMD_RX;
  byte_t in_rx_byte = '0;
  logic [CH_W-1:0] in_channel = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [STAT_W-1:0] out_status;
  byte_t out_read_data;
  logic [CNT_W-1:0] out_committed_length;
  logic cfg_wr_en = 1'b0;
  logic [CNT_W-1:0] cfg_wr_data = '0;

  length_framed_channel_loader_unit u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_command           (in_command),
    .in_rx_byte           (in_rx_byte),
    .in_channel           (in_channel),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_status           (out_status),
    .out_read_data        (out_read_data),
    .out_committed_length (out_committed_length),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_wr_data          (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mirror of the parser state and both memories.
  logic [PH_W-1:0]  parse_ph = PH_SEARCH;
  logic [LEN_W-1:0] frame_len = '0;
  logic [CNT_W-1:0] data_cnt = '0;
  logic             trail_good = 1'b1;
  logic [CNT_W-1:0] cfg_limit = MAX_LEN_RST;
  byte_t            staging [CHANNELS_DEF];
  byte_t            chan_mem [CHANNELS_DEF];

  plan_step_t     stream_plan [$];
  loader_result_t pending_results [$];
  loader_beat_t   cur_beat;
  int             beats_planned = 0;
  int             settle_cnt = 0;
  int             mismatches = 0;
  int             cycle_no = 0;
  logic           calm;

  // Neither side idles inside this window.
  assign calm = (cycle_no >= 600) && (cycle_no < 900);

  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
  end

  function automatic logic [PH_W-1:0] restart_phase(byte_t b);
    return (b == HDR_O) ? PH_GOT_O : PH_SEARCH;
  endfunction

  function automatic loader_result_t next_loader_result(loader_beat_t b);
    loader_result_t res;
    res.status = STAT_NONE;
    res.read_data = '0;
    res.committed_length = '0;
    if (b.command == CMD_READ) begin
      if (b.channel < CHANNELS_DEF) res.read_data = chan_mem[b.channel];
    end else begin
      case (parse_ph)
        PH_SEARCH: parse_ph = restart_phase(b.rx_byte);
        PH_GOT_O: parse_ph = (b.rx_byte == HDR_V) ? PH_GOT_OV : restart_phase(b.rx_byte);
        PH_GOT_OV: parse_ph = (b.rx_byte == HDR_D) ? PH_LEN_HI : restart_phase(b.rx_byte);
        PH_LEN_HI: begin
          frame_len = {b.rx_byte, 8'h00};
          parse_ph = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          frame_len = {frame_len[15:8], b.rx_byte};
          data_cnt = '0;
          trail_good = 1'b1;
          if (frame_len > cfg_limit || frame_len > CHANNELS_DEF) begin
            res.status = STAT_LONG;
            parse_ph = PH_SEARCH;
          end else begin
            parse_ph = (frame_len == 0) ? PH_TRAIL0 : PH_DATA;
          end
        end
        PH_DATA: begin
          if (data_cnt < CHANNELS_DEF) staging[data_cnt] = b.rx_byte;
          data_cnt = data_cnt + 1'b1;
          if (data_cnt >= frame_len) parse_ph = PH_TRAIL0;
        end
        PH_TRAIL0: begin
          trail_good = (b.rx_byte == 8'h00);
          parse_ph = PH_TRAIL1;
        end
        default: begin
          if (b.rx_byte != 8'h00) trail_good = 1'b0;
          if (trail_good && frame_len <= CHANNELS_DEF) begin
            for (int i = 0; i < frame_len; i++) chan_mem[i] = staging[i];
            res.status = STAT_COMMIT;
            res.committed_length = frame_len[CNT_W-1:0];
          end else begin
            res.status = STAT_TRAIL;
          end
          parse_ph = PH_SEARCH;
        end
      endcase
    end
    return res;
  endfunction

  function automatic void push_byte(byte_t b);
    plan_step_t s;
    s.kind = KIND_BEAT;
    s.beat.command = CMD_RX;
    s.beat.rx_byte = b;
    s.beat.channel = CH_W'($urandom);
    s.limit = '0;
    stream_plan.push_back(s);
    beats_planned++;
  endfunction

  function automatic void push_read(logic [CH_W-1:0] ch);
    plan_step_t s;
    s.kind = KIND_BEAT;
    s.beat.command = CMD_READ;
    s.beat.rx_byte = byte_t'($urandom);
    s.beat.channel = ch;
    s.limit = '0;
    stream_plan.push_back(s);
    beats_planned++;
  endfunction

  function automatic void push_control(step_kind_t kind, logic [CNT_W-1:0] limit);
    plan_step_t s;
    s.kind = kind;
    s.beat.command = CMD_RX;
    s.beat.rx_byte = '0;
    s.beat.channel = '0;
    s.limit = limit;
    stream_plan.push_back(s);
  endfunction

  // Header, length and, when the length is within the limit, data and trailer.
  function automatic void push_frame(logic [LEN_W-1:0] len, logic [CNT_W-1:0] limit,
                                     bit good_trail, bit mix_reads);
    byte_t t0;
    byte_t t1;
    push_byte(HDR_O);
    push_byte(HDR_V);
    push_byte(HDR_D);
    push_byte(len[15:8]);
    push_byte(len[7:0]);
    if (len <= limit && len <= CHANNELS_DEF) begin
      for (int i = 0; i < len; i++) begin
        push_byte(byte_t'($urandom));
        if (mix_reads && $urandom_range(9) == 0) push_read(CH_W'($urandom_range(31)));
      end
      t0 = 8'h00;
      t1 = 8'h00;
      if (!good_trail) begin
        case ($urandom_range(2))
          0: t0 = byte_t'($urandom_range(255, 1));
          1: t1 = byte_t'($urandom_range(255, 1));
          default: begin
            t0 = byte_t'($urandom_range(255, 1));
            t1 = byte_t'($urandom_range(255, 1));
          end
        endcase
      end
      push_byte(t0);
      push_byte(t1);
    end
  endfunction

  always @(posedge clk) begin : drive_proc
    bit fired;
    bit go;
    bit cfg_go;
    plan_step_t head;
    if (rst_n) begin
      fired = in_valid && !in_stall;
      if (fired) pending_results.push_back(next_loader_result(cur_beat));
      go = in_valid && !fired;
      cfg_go = 1'b0;
      if (!go && stream_plan.size() != 0) begin
        head = stream_plan[0];
        if (head.kind == KIND_BEAT) begin
          settle_cnt = 0;
          if (calm || $urandom_range(99) >= 33) begin
            head = stream_plan.pop_front();
            cur_beat = head.beat;
            in_command <= head.beat.command;
            in_rx_byte <= head.beat.rx_byte;
            in_channel <= head.beat.channel;
            go = 1'b1;
          end
        end else if (!fired && pending_results.size() == 0) begin
          // Everything is back; let the block settle before going on.
          if (settle_cnt < SETTLE_CYCLES) begin
            settle_cnt++;
          end else begin
            settle_cnt = 0;
            head = stream_plan.pop_front();
            if (head.kind == KIND_CFG) begin
              cfg_go = 1'b1;
              cfg_wr_data <= head.limit;
              cfg_limit = head.limit;
            end
          end
        end else begin
          settle_cnt = 0;
        end
      end
      in_valid <= go;
      cfg_wr_en <= cfg_go;
    end
  end

  always @(posedge clk) begin : check_proc
    loader_result_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("result beat with nothing expected: status %0d", out_status);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            mismatches++;
          end
          if (out_read_data !== want.read_data) begin
            $error("read_data: expected %0d, got %0d", want.read_data, out_read_data);
            mismatches++;
          end
          if (out_committed_length !== want.committed_length) begin
            $error("committed_length: expected %0d, got %0d",
                   want.committed_length, out_committed_length);
            mismatches++;
          end
        end
      end
      out_stall <= !calm && ($urandom_range(99) < 33);
    end
  end

  initial begin : stimulus_proc
    logic [CNT_W-1:0] limits [0:6];
    logic [CNT_W-1:0] plan_max;
    logic [LEN_W-1:0] len;
    int start;
    int pick;
    int sel;
    int cap;
    for (int i = 0; i < CHANNELS_DEF; i++) begin
      chan_mem[i] = '0;
      staging[i] = '0;
    end
    limits = '{10'd512, 10'd0, 10'd1023, 10'd9, 10'd300, 10'd1, 10'd512};

    // Directed part, run with the reset limit.
    push_read(CH_W'(511));
    // A broken header whose breaking byte is an 'O' starts the next match.
    push_byte(HDR_O);
    push_byte(HDR_V);
    push_byte(HDR_O);
    push_byte(HDR_V);
    push_byte(HDR_D);
    push_byte(8'h00);
    push_byte(8'h01);
    push_byte(8'hff);
    push_byte(8'h00);
    push_byte(8'h00);
    push_frame(16'h0000, MAX_LEN_RST, 1'b1, 1'b0);
    push_frame(16'hffff, MAX_LEN_RST, 1'b1, 1'b0);
    push_read(CH_W'(0));

    // Random part, one phase per limit setting.
    for (int p = 0; p < 7; p++) begin
      plan_max = limits[p];
      push_control(KIND_CFG, plan_max);
      start = beats_planned;
      if (p == 0) begin
        push_frame(LEN_W'(LONG_FRAME), plan_max, 1'b1, 1'b0);
        push_read(CH_W'(511));
        push_read(CH_W'(LONG_FRAME - 1));
      end
      if (plan_max > CHANNELS_DEF) push_frame(LEN_W'(CHANNELS_DEF + 1), plan_max, 1'b1, 1'b0);
      while (beats_planned - start < PHASE_BEATS) begin
        if (p == 3 && beats_planned - start > PHASE_BEATS / 2 && settle_cnt == 0) begin
          push_control(KIND_DRAIN, '0);
          settle_cnt = -1;
        end
        pick = $urandom_range(99);
        if (pick < 65) begin
          sel = $urandom_range(9);
          cap = (plan_max < 12) ? plan_max : 12;
          if (sel < 6) len = LEN_W'($urandom_range(cap, 0));
          else if (sel < 8) len = LEN_W'(plan_max) + LEN_W'($urandom_range(4, 1));
          else if (sel == 8) len = LEN_W'($urandom);
          else len = LEN_W'($urandom_range(24, 0));
          push_frame(len, plan_max, $urandom_range(9) < 8, 1'b1);
        end else if (pick < 80) begin
          if ($urandom_range(9) < 7) push_read(CH_W'($urandom_range(31)));
          else push_read(CH_W'($urandom));
        end else begin
          case ($urandom_range(2))
            0: repeat ($urandom_range(4, 1)) push_byte(byte_t'($urandom));
            1: begin
              push_byte(HDR_O);
              push_byte(HDR_V);
              push_byte(byte_t'($urandom));
            end
            default: begin
              push_byte(HDR_O);
              push_byte(byte_t'($urandom));
            end
          endcase
        end
      end
    end
    settle_cnt = 0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (stream_plan.size() != 0 || in_valid) @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : watchdog_proc
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

`default_nettype wire
